@@ design/rbezc_pkg.sv @@
// ---------------------------------------------------------------------------
// rbezc_pkg: shared types and constants for the exclusion zone check
// Field widths, command codes, the zone entry and bin types, and the
// per-lane control group used between the top level and the zone lanes.
// ---------------------------------------------------------------------------
package rbezc_pkg;

	localparam int ZONES_DEFAULT = 16;
	localparam int SLOT_W        = 4;
	localparam int ELEV_W        = 11;
	localparam int AZM_W         = 12;
	localparam int RNG_W         = 19;
	localparam int NZ_W          = 5;
	localparam int GROUP         = 8;

	localparam logic CMD_CHECK = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef struct packed {
		logic signed [ELEV_W-1:0] elev;
		logic        [AZM_W-1:0]  azm_lo;
		logic        [AZM_W-1:0]  azm_hi;
		logic        [RNG_W-1:0]  range_lo;
		logic        [RNG_W-1:0]  range_hi;
	} zone_t;

	typedef struct packed {
		logic        [AZM_W-1:0]  azimuth;
		logic        [RNG_W-1:0]  range;
		logic signed [ELEV_W-1:0] elevation;
	} bin_t;

	typedef struct packed {
		logic wr_en;
		logic active;
	} lane_ctl_t;

endpackage

@@ design/rbezc_if.sv @@
// ---------------------------------------------------------------------------
// rbezc_if: channel interfaces for the exclusion zone check
// Request, result and configuration channels, each with valid, ready and
// its payload, and a source and a sink modport.
// ---------------------------------------------------------------------------
interface rbezc_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 cmd;
	logic        [rbezc_pkg::SLOT_W-1:0]  zone_slot;
	logic signed [rbezc_pkg::ELEV_W-1:0]  zone_elev_limit;
	logic        [rbezc_pkg::AZM_W-1:0]   zone_azm_start;
	logic        [rbezc_pkg::AZM_W-1:0]   zone_azm_end;
	logic        [rbezc_pkg::RNG_W-1:0]   zone_range_start;
	logic        [rbezc_pkg::RNG_W-1:0]   zone_range_end;
	logic        [rbezc_pkg::AZM_W-1:0]   bin_azimuth;
	logic        [rbezc_pkg::RNG_W-1:0]   bin_range;
	logic signed [rbezc_pkg::ELEV_W-1:0]  bin_elevation;

	modport source (
		output valid, cmd, zone_slot, zone_elev_limit, zone_azm_start, zone_azm_end,
		       zone_range_start, zone_range_end, bin_azimuth, bin_range, bin_elevation,
		input  ready
	);
	modport sink (
		input  valid, cmd, zone_slot, zone_elev_limit, zone_azm_start, zone_azm_end,
		       zone_range_start, zone_range_end, bin_azimuth, bin_range, bin_elevation,
		output ready
	);
endinterface

interface rbezc_rsp_if;
	logic valid;
	logic ready;
	logic excluded;

	modport source (output valid, excluded, input ready);
	modport sink   (input valid, excluded, output ready);
endinterface

interface rbezc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [rbezc_pkg::NZ_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

@@ design/rbezc_zone_lane.sv @@
// ---------------------------------------------------------------------------
// rbezc_zone_lane: one zone entry and its comparator
// Holds one zone and tests a bin against it: elevation at or below the
// limit, range inside both ends, and the azimuth test with wrap support.
// ---------------------------------------------------------------------------
module rbezc_zone_lane (
	input  logic                 clk,
	input  rbezc_pkg::lane_ctl_t ctl,
	input  rbezc_pkg::zone_t     wr_entry,
	input  rbezc_pkg::bin_t      bin,
	output logic                 hit
);

	rbezc_pkg::zone_t entry_q;
	logic             az_ok;
	logic             el_ok;
	logic             rng_ok;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			entry_q <= wr_entry;
		end
	end

	always_comb begin
		if (entry_q.azm_lo < entry_q.azm_hi) begin
			az_ok = (bin.azimuth >= entry_q.azm_lo) && (bin.azimuth <= entry_q.azm_hi);
		end else begin
			// The zone wraps through north, so either bound is enough.
			az_ok = (bin.azimuth >= entry_q.azm_lo) || (bin.azimuth <= entry_q.azm_hi);
		end
		el_ok  = (bin.elevation <= entry_q.elev);
		rng_ok = (bin.range >= entry_q.range_lo) && (bin.range <= entry_q.range_hi);
	end

	assign hit = ctl.active && az_ok && el_ok && rng_ok;

endmodule

@@ design/rbezc_hit_reduce.sv @@
// ---------------------------------------------------------------------------
// rbezc_hit_reduce: registered OR tree over the lane hits
// Folds groups of lane hits in one stage and the group results in a second
// stage, which is also the output register of the result channel.
// ---------------------------------------------------------------------------
module rbezc_hit_reduce #(
	parameter int ZONES = rbezc_pkg::ZONES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hit_valid,
	input  logic [ZONES-1:0]   hits,
	output logic               hit_ready,
	rbezc_rsp_if.source        rsp
);

	localparam int NGRP = (ZONES + rbezc_pkg::GROUP - 1) / rbezc_pkg::GROUP;
	localparam int PADW = NGRP * rbezc_pkg::GROUP;

	logic [PADW-1:0] hits_pad;
	logic [NGRP-1:0] grp_or;
	logic [NGRP-1:0] grp_s3;
	logic            v_s3;
	logic            v_s4;
	logic            excl_s4;
	logic            rdy3;
	logic            rdy4;

	assign hits_pad = PADW'(hits);

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = |hits_pad[g*rbezc_pkg::GROUP +: rbezc_pkg::GROUP];
		end
	end

	assign rdy4      = !v_s4 || rsp.ready;
	assign rdy3      = !v_s3 || rdy4;
	assign hit_ready = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy3) begin
				v_s3 <= hit_valid;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && hit_valid) begin
			grp_s3 <= grp_or;
		end
		if (rdy4 && v_s3) begin
			excl_s4 <= |grp_s3;
		end
	end

	assign rsp.valid    = v_s4;
	assign rsp.excluded = excl_s4;

endmodule

@@ design/radar_bin_exclusion_zone_check.sv @@
// ---------------------------------------------------------------------------
// radar_bin_exclusion_zone_check: radar bin versus exclusion zone table
// Stores up to ZONES zones and flags each checked bin that lies in an
// active zone, with one comparator lane per zone.
// ---------------------------------------------------------------------------
// The block takes one item per clock cycle when the result side keeps up.
// A write item stores a zone, with its range ends put in order, and gives
// no result. A check item gives one result, the excluded flag, which is
// presented on the result channel from the last of its stages: stage one
// registers the item, stage two holds the hit of every zone lane, which
// all compare in parallel, stage three holds the OR of each group of eight
// lanes, and stage four is the output register. Writes update the table
// as they leave stage one, which is also where checks read it, so every
// check sees exactly the writes accepted before it. Only zones below the
// zone count take part; the user must write the zone count on the
// configuration channel only while no item is in flight, which the block
// itself does not enforce. A stalled result holds the pipeline back stage
// by stage, and bubbles are squeezed out.
module radar_bin_exclusion_zone_check #(
	parameter int ZONES = rbezc_pkg::ZONES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	rbezc_req_if.sink   req,
	rbezc_rsp_if.source rsp,
	rbezc_cfg_if.sink   cfg
);

	// Configuration register.
	logic [rbezc_pkg::NZ_W-1:0] zone_count_q;

	// Stage one: the accepted item.
	logic                                v_s1;
	logic                                cmd_s1;
	logic [rbezc_pkg::SLOT_W-1:0]        slot_s1;
	logic signed [rbezc_pkg::ELEV_W-1:0] elev_s1;
	logic [rbezc_pkg::AZM_W-1:0]         azm_start_s1;
	logic [rbezc_pkg::AZM_W-1:0]         azm_end_s1;
	logic [rbezc_pkg::RNG_W-1:0]         rng_start_s1;
	logic [rbezc_pkg::RNG_W-1:0]         rng_end_s1;
	rbezc_pkg::bin_t                     bin_s1;

	// Stage two: lane hits of a check.
	logic             v_s2;
	logic [ZONES-1:0] hits_s2;

	logic                 is_wr_s1;
	logic                 s1_go;
	logic                 rdy2;
	logic                 rdy3;
	logic                 accept;
	logic [ZONES-1:0]     hit_vec;
	rbezc_pkg::zone_t     entry_s1;
	rbezc_pkg::lane_ctl_t ctl [ZONES];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_count_q <= '0;
		end else if (cfg.valid) begin
			zone_count_q <= cfg.data;
		end
	end

	// A write leaves stage one at once; a check needs room in stage two.
	assign is_wr_s1  = (cmd_s1 == rbezc_pkg::CMD_WRITE);
	assign rdy2      = !v_s2 || rdy3;
	assign s1_go     = v_s1 && (is_wr_s1 || rdy2);
	assign req.ready = !v_s1 || s1_go;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			if (rdy2) begin
				v_s2 <= s1_go && !is_wr_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1            <= req.cmd;
			slot_s1           <= req.zone_slot;
			elev_s1           <= req.zone_elev_limit;
			azm_start_s1      <= req.zone_azm_start;
			azm_end_s1        <= req.zone_azm_end;
			rng_start_s1      <= req.zone_range_start;
			rng_end_s1        <= req.zone_range_end;
			bin_s1.azimuth    <= req.bin_azimuth;
			bin_s1.range      <= req.bin_range;
			bin_s1.elevation  <= req.bin_elevation;
		end
		if (rdy2 && s1_go && !is_wr_s1) begin
			hits_s2 <= hit_vec;
		end
	end

	// The smaller range end is stored first.
	always_comb begin
		entry_s1.elev   = elev_s1;
		entry_s1.azm_lo = azm_start_s1;
		entry_s1.azm_hi = azm_end_s1;
		if (rng_end_s1 < rng_start_s1) begin
			entry_s1.range_lo = rng_end_s1;
			entry_s1.range_hi = rng_start_s1;
		end else begin
			entry_s1.range_lo = rng_start_s1;
			entry_s1.range_hi = rng_end_s1;
		end
	end

	// One lane per zone. A slot beyond the table matches no lane and is
	// dropped. A lane is active when its index is below the zone count,
	// which also covers a count above the table size.
	for (genvar i = 0; i < ZONES; i++) begin : g_lane
		assign ctl[i].wr_en  = s1_go && is_wr_s1 && (32'(slot_s1) == i);
		assign ctl[i].active = (i < 32'(zone_count_q));

		rbezc_zone_lane u_lane (
			.clk      (clk),
			.ctl      (ctl[i]),
			.wr_entry (entry_s1),
			.bin      (bin_s1),
			.hit      (hit_vec[i])
		);
	end

	rbezc_hit_reduce #(
		.ZONES (ZONES)
	) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.hit_valid (v_s2),
		.hits      (hits_s2),
		.hit_ready (rdy3),
		.rsp       (rsp)
	);

endmodule

@@ design/rbezc_checker.sv @@
// ---------------------------------------------------------------------------
// rbezc_checker: port-level assertions for the exclusion zone check
// Watches the channels of the top level and is bound to it below.
// ---------------------------------------------------------------------------
module rbezc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_excluded,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic [rbezc_pkg::NZ_W-1:0]   cfg_data
);

	logic [rbezc_pkg::NZ_W-1:0] nz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			nz_q <= cfg_data;
		end
	end

	// A stalled result keeps its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_excluded))
		else $error("result changed while stalled");

	// With no zone in use nothing can be excluded.
	a_no_zone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_excluded |-> nz_q != '0)
		else $error("bin excluded with no active zone");

	// The input side backs up only when the full pipeline waits on the result.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("input stalled while the result side is free");

endmodule

bind radar_bin_exclusion_zone_check rbezc_checker u_rbezc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_excluded (rsp.excluded),
	.cfg_valid    (cfg.valid),
	.cfg_ready    (cfg.ready),
	.cfg_data     (cfg.data)
);
